/* rtl/core/ssp_pkg.sv */
// Shared types and constants for the service slot pool.
// Holds the action codes, controller states and the controller command struct.
// Has no dependencies.
package ssp_pkg;

	localparam int SERVERS_BITS = 5;
	localparam int SLOT_IDX_BITS = 4;
	localparam int FIELD_BITS = 16;
	localparam int GROUP_SIZE = 8;
	localparam int GROUP_BITS = 3;

	typedef enum logic [1:0] {
		ACT_TICK,
		ACT_ASSIGN,
		ACT_RELEASE,
		ACT_CLEAR
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_GROUP,
		ST_TOTAL
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic group;
		logic total;
	} ssp_cmd_t;

endpackage

/* rtl/core/ssp_ctrl.sv */
// Controller state machine of the service slot pool.
// Sequences capture, update, group summary and total for each transaction.
// Depends on ssp_pkg.
module ssp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output ssp_pkg::ssp_cmd_t cmd,
	output logic            busy,
	output logic            done
);
	import ssp_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   done_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_APPLY;
				end
			end
			ST_APPLY: state_next = ST_GROUP;
			ST_GROUP: state_next = ST_TOTAL;
			ST_TOTAL: state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = start;
				busy = 1'b0;
			end
			ST_APPLY: cmd.apply = 1'b1;
			ST_GROUP: cmd.group = 1'b1;
			ST_TOTAL: cmd.total = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_next;
			done_q <= (state_q == ST_TOTAL);
		end
	end

	assign done = done_q;

endmodule

/* rtl/core/ssp_slots.sv */
// Slot storage datapath of the service slot pool.
// Holds the in-use register and slot records, applies actions and reads out the addressed slot.
// Depends on ssp_pkg.
module ssp_slots #(
	parameter int SLOT_COUNT = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ssp_pkg::ssp_cmd_t                     cmd,
	input  logic                                  cfg_we,
	input  logic [ssp_pkg::SERVERS_BITS-1:0]      cfg_wdata,
	input  logic [1:0]                            action,
	input  logic [ssp_pkg::SLOT_IDX_BITS-1:0]     slot,
	input  logic [ssp_pkg::FIELD_BITS-1:0]        service_time,
	input  logic [ssp_pkg::FIELD_BITS-1:0]        client_number,
	input  logic [ssp_pkg::FIELD_BITS-1:0]        extra_word,
	output logic [SLOT_COUNT-1:0]                 count_vec,
	output logic [SLOT_COUNT-1:0]                 free_vec,
	output logic [ssp_pkg::FIELD_BITS-1:0]        slot_time,
	output logic [ssp_pkg::FIELD_BITS-1:0]        slot_client,
	output logic [ssp_pkg::FIELD_BITS-1:0]        slot_extra,
	output logic                                  slot_free,
	output logic                                  slot_finished,
	output logic                                  bad_slot
);
	import ssp_pkg::*;

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [SERVERS_BITS-1:0]  servers_q;
	action_t                  act_q;
	logic [SLOT_IDX_BITS-1:0] slot_q;
	logic [TIME_BITS-1:0]     time_in_q;
	logic [FIELD_BITS-1:0]    client_in_q;
	logic [FIELD_BITS-1:0]    extra_in_q;

	logic [TIME_BITS-1:0]     time_q [SLOT_COUNT];
	logic [FIELD_BITS-1:0]    client_q [SLOT_COUNT];
	logic [FIELD_BITS-1:0]    extra_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]    ticked_q;

	logic [SLOT_COUNT-1:0]    active;
	logic [SLOT_COUNT-1:0]    nz;
	logic                     bad;
	logic [IW-1:0]            idx;
	logic [TIME_BITS-1:0]     rd_time;
	logic [FIELD_BITS-1:0]    rd_client;
	logic [FIELD_BITS-1:0]    rd_extra;

	logic [FIELD_BITS-1:0]    slot_time_q;
	logic [FIELD_BITS-1:0]    slot_client_q;
	logic [FIELD_BITS-1:0]    slot_extra_q;
	logic                     slot_free_q;
	logic                     slot_finished_q;
	logic                     bad_slot_q;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			active[i] = (i < int'(servers_q));
			nz[i] = (time_q[i] != '0);
		end
		bad = ({1'b0, slot_q} >= servers_q) || (int'(slot_q) >= SLOT_COUNT);
		idx = IW'(slot_q);
		count_vec = (act_q == ACT_TICK) ? ticked_q : (active & nz);
		free_vec = active & ~nz;
		rd_time = time_q[idx];
		rd_client = client_q[idx];
		rd_extra = extra_q[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servers_q <= SERVERS_BITS'(1);
		end else if (cfg_we) begin
			servers_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action_t'(action);
			slot_q <= slot;
			time_in_q <= TIME_BITS'(service_time);
			client_in_q <= client_number;
			extra_in_q <= extra_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticked_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				time_q[i] <= '0;
				client_q[i] <= '0;
				extra_q[i] <= '0;
			end
		end else if (cmd.apply) begin
			ticked_q <= active & nz;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				case (act_q)
					ACT_TICK: begin
						if (active[i] && nz[i]) begin
							time_q[i] <= time_q[i] - TIME_BITS'(1);
						end
					end
					ACT_ASSIGN: begin
						if (!bad && idx == IW'(i)) begin
							time_q[i] <= time_in_q;
							client_q[i] <= client_in_q;
							extra_q[i] <= extra_in_q;
						end
					end
					ACT_RELEASE: begin
						if (!bad && idx == IW'(i)) begin
							time_q[i] <= '0;
							client_q[i] <= '0;
							extra_q[i] <= '0;
						end
					end
					default: begin
						if (active[i]) begin
							time_q[i] <= '0;
							client_q[i] <= '0;
							extra_q[i] <= '0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.total) begin
			bad_slot_q <= bad;
			if (bad) begin
				slot_time_q <= '0;
				slot_client_q <= '0;
				slot_extra_q <= '0;
				slot_free_q <= 1'b0;
				slot_finished_q <= 1'b0;
			end else begin
				slot_time_q <= FIELD_BITS'(rd_time);
				slot_client_q <= rd_client;
				slot_extra_q <= rd_extra;
				slot_free_q <= (rd_time == '0) && (rd_client == '0) && (rd_extra == '0);
				slot_finished_q <= (rd_time == '0) && (rd_client != '0);
			end
		end
	end

	assign slot_time = slot_time_q;
	assign slot_client = slot_client_q;
	assign slot_extra = slot_extra_q;
	assign slot_free = slot_free_q;
	assign slot_finished = slot_finished_q;
	assign bad_slot = bad_slot_q;

endmodule

/* rtl/core/ssp_summary.sv */
// Pool summary datapath of the service slot pool.
// A registered two-level tree that counts busy slots and finds the first free slot.
// Depends on ssp_pkg.
module ssp_summary #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                              clk,
	input  ssp_pkg::ssp_cmd_t                 cmd,
	input  logic [SLOT_COUNT-1:0]             count_vec,
	input  logic [SLOT_COUNT-1:0]             free_vec,
	output logic [ssp_pkg::SERVERS_BITS-1:0]  first_free,
	output logic [ssp_pkg::SERVERS_BITS-1:0]  busy_count
);
	import ssp_pkg::*;

	localparam int NG = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PADN = NG * GROUP_SIZE;
	localparam int CW = $clog2(SLOT_COUNT + 1);

	logic [PADN-1:0]       cnt_pad;
	logic [PADN-1:0]       free_pad;
	logic [GROUP_BITS:0]   grp_cnt [NG];
	logic                  grp_hit [NG];
	logic [GROUP_BITS-1:0] grp_pos [NG];
	logic [GROUP_BITS:0]   grp_cnt_s1 [NG];
	logic                  grp_hit_s1 [NG];
	logic [GROUP_BITS-1:0] grp_pos_s1 [NG];
	logic [CW-1:0]         sum;
	logic [CW-1:0]         first;
	logic [CW-1:0]         sum_q;
	logic [CW-1:0]         first_q;

	always_comb begin
		cnt_pad = PADN'(count_vec);
		free_pad = PADN'(free_vec);
		for (int g = 0; g < NG; g++) begin
			grp_cnt[g] = '0;
			grp_hit[g] = 1'b0;
			grp_pos[g] = '0;
			for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
				grp_cnt[g] = grp_cnt[g] + (GROUP_BITS + 1)'(cnt_pad[g * GROUP_SIZE + b]);
				if (free_pad[g * GROUP_SIZE + b]) begin
					grp_hit[g] = 1'b1;
					grp_pos[g] = GROUP_BITS'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.group) begin
			for (int g = 0; g < NG; g++) begin
				grp_cnt_s1[g] <= grp_cnt[g];
				grp_hit_s1[g] <= grp_hit[g];
				grp_pos_s1[g] <= grp_pos[g];
			end
		end
	end

	always_comb begin
		sum = '0;
		first = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			sum = sum + CW'(grp_cnt_s1[g]);
			if (grp_hit_s1[g]) begin
				first = CW'(g * GROUP_SIZE) + CW'(grp_pos_s1[g]) + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.total) begin
			sum_q <= sum;
			first_q <= first;
		end
	end

	assign first_free = SERVERS_BITS'(first_q);
	assign busy_count = SERVERS_BITS'(sum_q);

endmodule

/* rtl/core/service_slot_pool.sv */
// Top level of the service slot pool.
// Joins the controller, the slot storage and the summary tree.
// Depends on ssp_pkg, ssp_ctrl, ssp_slots and ssp_summary.

// A transaction runs as follows: start is taken while busy is low, busy then
// stays high while the slot records are updated, the per-group counts are
// registered and the totals are formed, and once the totals are registered
// done is high for exactly one cycle with all result ports valid. That cycle
// is also the first in which busy is low again, so a new start may be given
// in it. The receiver must take the result when done is high; it cannot be
// held. The user must write the in-use count through cfg_we and cfg_wdata
// only while no transaction is open; the block itself does not enforce this.
module service_slot_pool #(
	parameter int SLOT_COUNT = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ssp_pkg::SERVERS_BITS-1:0]     cfg_wdata,
	input  logic                                 start,
	input  logic [1:0]                           action,
	input  logic [ssp_pkg::SLOT_IDX_BITS-1:0]    slot,
	input  logic [ssp_pkg::FIELD_BITS-1:0]       service_time,
	input  logic [ssp_pkg::FIELD_BITS-1:0]       client_number,
	input  logic [ssp_pkg::FIELD_BITS-1:0]       extra_word,
	output logic                                 busy,
	output logic                                 done,
	output logic [ssp_pkg::SERVERS_BITS-1:0]     first_free,
	output logic [ssp_pkg::SERVERS_BITS-1:0]     busy_count,
	output logic [ssp_pkg::FIELD_BITS-1:0]       slot_time,
	output logic [ssp_pkg::FIELD_BITS-1:0]       slot_client,
	output logic [ssp_pkg::FIELD_BITS-1:0]       slot_extra,
	output logic                                 slot_free,
	output logic                                 slot_finished,
	output logic                                 bad_slot
);
	import ssp_pkg::*;

	ssp_cmd_t              cmd;
	logic [SLOT_COUNT-1:0] count_vec;
	logic [SLOT_COUNT-1:0] free_vec;

	ssp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ssp_slots #(
		.SLOT_COUNT (SLOT_COUNT),
		.TIME_BITS  (TIME_BITS)
	) u_slots (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.action        (action),
		.slot          (slot),
		.service_time  (service_time),
		.client_number (client_number),
		.extra_word    (extra_word),
		.count_vec     (count_vec),
		.free_vec      (free_vec),
		.slot_time     (slot_time),
		.slot_client   (slot_client),
		.slot_extra    (slot_extra),
		.slot_free     (slot_free),
		.slot_finished (slot_finished),
		.bad_slot      (bad_slot)
	);

	ssp_summary #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_summary (
		.clk        (clk),
		.cmd        (cmd),
		.count_vec  (count_vec),
		.free_vec   (free_vec),
		.first_free (first_free),
		.busy_count (busy_count)
	);

`ifndef NO_ASSERTIONS
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result strobe did not follow an accepted transaction");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a transaction is open");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy raised without an accepted transaction");
`endif

endmodule
